@@ design/lr_pkg.sv @@
// Shared types and constants for the line rasterizer.
`default_nettype none

package lr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int STRIDE_W       = 13;
    localparam int ADDR_W         = 24;
    localparam int COLOR_W        = 32;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(640);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    // Per-cycle commands from the pipeline control to the line engine.
    typedef struct packed {
        logic load;
        logic step;
    } t_core_ctl;

endpackage

`default_nettype wire

@@ design/lr_core.sv @@
// Bresenham line state and step update.
`default_nettype none

module lr_core
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_core_ctl             i_ctl,
    input  wire logic [COORD_BITS-1:0] i_x_start,
    input  wire logic [COORD_BITS-1:0] i_y_start,
    input  wire logic [COORD_BITS-1:0] i_x_end,
    input  wire logic [COORD_BITS-1:0] i_y_end,
    input  wire logic [COLOR_W-1:0]    i_line_color,
    output logic                       o_emit,
    output logic [COORD_BITS-1:0]      o_pixel_x,
    output logic [COORD_BITS-1:0]      o_pixel_y,
    output logic [COLOR_W-1:0]         o_pixel_value,
    output logic                       o_last_pixel
);

    localparam int DX_W  = COORD_BITS + 1;
    localparam int NDY_W = COORD_BITS + 2;
    localparam int ERR_W = COORD_BITS + 3;
    localparam int TW_W  = COORD_BITS + 4;

    logic [COORD_BITS-1:0]   r_cur_x, r_cur_y, r_target_x, r_target_y;
    logic [DX_W-1:0]         r_delta_x;
    logic signed [NDY_W-1:0] r_neg_delta_y;
    logic                    r_step_x_neg, r_step_y_neg;
    logic signed [ERR_W-1:0] r_error_term;
    logic [COLOR_W-1:0]      r_held_color;
    logic                    r_busy;

    // load-side derived values
    logic [COORD_BITS-1:0]   ld_dx, ld_dy;
    logic signed [NDY_W-1:0] ld_ndy;
    logic signed [ERR_W-1:0] ld_err;

    // step-side values
    logic                    last;
    logic signed [TW_W-1:0]  twice;
    logic                    move_x, move_y;
    logic signed [ERR_W-1:0] add_x, add_y;

    logic [COORD_BITS-1:0]   n_cur_x, n_cur_y;
    logic signed [ERR_W-1:0] n_error_term;

    always_comb begin
        ld_dx  = (i_x_end >= i_x_start) ? (i_x_end - i_x_start) : (i_x_start - i_x_end);
        ld_dy  = (i_y_end >= i_y_start) ? (i_y_end - i_y_start) : (i_y_start - i_y_end);
        ld_ndy = -$signed({2'b00, ld_dy});
        ld_err = $signed({3'b000, ld_dx}) + ERR_W'(ld_ndy);

        last   = (r_cur_x == r_target_x) && (r_cur_y == r_target_y);
        twice  = $signed({r_error_term, 1'b0});
        move_x = twice >= TW_W'(r_neg_delta_y);
        move_y = twice <= $signed({3'b000, r_delta_x});
        add_x  = move_x ? ERR_W'(r_neg_delta_y) : '0;
        add_y  = move_y ? $signed({2'b00, r_delta_x}) : '0;

        n_error_term = r_error_term + add_x + add_y;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (move_x) begin
            n_cur_x = r_step_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        end
        if (move_y) begin
            n_cur_y = r_step_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_target_x    <= '0;
            r_target_y    <= '0;
            r_delta_x     <= '0;
            r_neg_delta_y <= '0;
            r_step_x_neg  <= 1'b0;
            r_step_y_neg  <= 1'b0;
            r_error_term  <= '0;
            r_held_color  <= '0;
            r_busy        <= 1'b0;
        end else if (i_ctl.load) begin
            r_cur_x       <= i_x_start;
            r_cur_y       <= i_y_start;
            r_target_x    <= i_x_end;
            r_target_y    <= i_y_end;
            r_step_x_neg  <= !(i_x_start < i_x_end);
            r_step_y_neg  <= !(i_y_start < i_y_end);
            r_delta_x     <= {1'b0, ld_dx};
            r_neg_delta_y <= ld_ndy;
            r_error_term  <= ld_err;
            r_held_color  <= i_line_color;
            r_busy        <= 1'b1;
        end else if (i_ctl.step && r_busy) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_cur_x      <= n_cur_x;
                r_cur_y      <= n_cur_y;
                r_error_term <= n_error_term;
            end
        end
    end

    assign o_emit        = i_ctl.step && r_busy;
    assign o_pixel_x     = r_cur_x;
    assign o_pixel_y     = r_cur_y;
    assign o_pixel_value = r_held_color;
    assign o_last_pixel  = last;

endmodule

`default_nettype wire

@@ design/line_rasterizer_unit.sv @@
// Top level of the Bresenham line rasterizer: handshake, stride register, address.
`default_nettype none

// Bresenham line rasterizer. A load transfer (op = LOAD) latches two end points
// and a color and arms the engine; it produces no pixel. Each step transfer
// (op = STEP) while a line is active produces one pixel with its column, row,
// linear address (row * line_stride + column, modulo 2^24), color, and a last
// flag on the end point, after which the engine goes idle. Steps while idle
// produce nothing; a load during a line replaces it. Every direction is drawn,
// including vertical, horizontal and reversed lines; no clipping is done.
// Throughput is one transfer per clock, sustained, with no bubbles while the
// output is not stalled: the Bresenham update (two adds and two compares) and
// the 12x13 address multiply both fit in the single stage between the input
// register and the result register. A pixel passes the input and then the
// result registers after its step is accepted. line_stride is a plain register
// (o_cfg_ready is always high); change it only while no pixels are pending.
module line_rasterizer_unit
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item input
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_op,
    input  wire logic [COORD_BITS-1:0] i_x_start,
    input  wire logic [COORD_BITS-1:0] i_y_start,
    input  wire logic [COORD_BITS-1:0] i_x_end,
    input  wire logic [COORD_BITS-1:0] i_y_end,
    input  wire logic [COLOR_W-1:0]    i_line_color,
    // pixel output
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [COORD_BITS-1:0]      o_pixel_x,
    output logic [COORD_BITS-1:0]      o_pixel_y,
    output logic [ADDR_W-1:0]          o_pixel_address,
    output logic [COLOR_W-1:0]         o_pixel_value,
    output logic                       o_last_pixel,
    // configuration
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [STRIDE_W-1:0]   i_cfg_line_stride
);

    localparam int MUL_W = COORD_BITS + STRIDE_W;
    localparam int SUM_W = ((MUL_W > ADDR_W) ? MUL_W : ADDR_W) + 1;

    // input register
    logic                  r_in_valid;
    logic                  r_in_op;
    logic [COORD_BITS-1:0] r_in_x_start, r_in_y_start, r_in_x_end, r_in_y_end;
    logic [COLOR_W-1:0]    r_in_color;

    // result register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [ADDR_W-1:0]     r_out_addr;
    logic [COLOR_W-1:0]    r_out_color;
    logic                  r_out_last;

    logic [STRIDE_W-1:0]   r_line_stride;

    logic                  advance;     // input stage moves on this cycle
    logic                  in_take;
    t_core_ctl             core_ctl;
    logic                  emit;
    logic [COORD_BITS-1:0] pix_x, pix_y;
    logic [COLOR_W-1:0]    pix_color;
    logic                  pix_last;
    logic [MUL_W-1:0]      row_base;
    logic [SUM_W-1:0]      addr_sum;

    // result slot is free or being drained this cycle
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        core_ctl.load = r_in_valid && advance && (t_op'(r_in_op) == OP_LOAD);
        core_ctl.step = r_in_valid && advance && (t_op'(r_in_op) == OP_STEP);
    end

    lr_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (core_ctl),
        .i_x_start     (r_in_x_start),
        .i_y_start     (r_in_y_start),
        .i_x_end       (r_in_x_end),
        .i_y_end       (r_in_y_end),
        .i_line_color  (r_in_color),
        .o_emit        (emit),
        .o_pixel_x     (pix_x),
        .o_pixel_y     (pix_y),
        .o_pixel_value (pix_color),
        .o_last_pixel  (pix_last)
    );

    // linear address, wraps modulo 2^ADDR_W
    assign row_base = MUL_W'(pix_y) * MUL_W'(r_line_stride);
    assign addr_sum = SUM_W'(row_base) + SUM_W'(pix_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op      <= i_op;
            r_in_x_start <= i_x_start;
            r_in_y_start <= i_y_start;
            r_in_x_end   <= i_x_end;
            r_in_y_end   <= i_y_end;
            r_in_color   <= i_line_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_x     <= pix_x;
            r_out_y     <= pix_y;
            r_out_addr  <= addr_sum[ADDR_W-1:0];
            r_out_color <= pix_color;
            r_out_last  <= pix_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_stride <= STRIDE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_line_stride <= i_cfg_line_stride;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_pixel_x       = r_out_x;
    assign o_pixel_y       = r_out_y;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_value   = r_out_color;
    assign o_last_pixel    = r_out_last;

endmodule

`default_nettype wire
